// ===== rtl/core/sfb_pkg.sv =====
// Shared types and constants of the segmenting frame builder.
// No dependencies.
package sfb_pkg;

  localparam int MAX_RESULTS = 35;
  localparam logic [7:0] START_MARK = 8'h7E;
  localparam int FRAME_OVERHEAD = 5;

  typedef enum logic [1:0] {
    CFG_SEQ      = 2'd0,
    CFG_END_TYPE = 2'd1,
    CFG_MIN_LEN  = 2'd2,
    CFG_PAD      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] seq;
    logic [7:0] end_type;
    logic [4:0] min_len;
    logic [7:0] pad;
  } cfg_t;

  typedef struct packed {
    logic       has_data;
    logic       has_end;
    logic [7:0] len;
    logic [7:0] ppar;
    logic [7:0] ftype;
    logic       bank;
  } cmd_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] idx;
    logic [7:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic done;
    logic bank;
  } back_done_t;

endpackage

// ===== rtl/core/sfb_front.sv =====
// Front end: accepts input items, fills the piece store and classifies items
// into frame commands. Depends on sfb_pkg.
module sfb_front import sfb_pkg::*; #(
  parameter int PIECE_BYTES = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_message,
  input  logic [7:0] in_frame_type,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd,
  output mem_wr_t    mem_wr,
  input  back_done_t bk_done
);

  localparam int CNT_W = $clog2(PIECE_BYTES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_a;
  logic [7:0]       par_r, par_nxt, par_a;
  logic             sent_r, sent_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             accept, full;

  assign in_stall = q_full || (in_byte_present && busy_r[bank_r]);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cnt_nxt  = cnt_r;
    par_nxt  = par_r;
    sent_nxt = sent_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    cnt_a    = cnt_r;
    par_a    = par_r;
    full     = 1'b0;
    q_push   = 1'b0;
    q_cmd    = '0;
    mem_wr.en   = accept && in_byte_present;
    mem_wr.bank = bank_r;
    mem_wr.idx  = 8'(cnt_r);
    mem_wr.data = in_payload_byte;
    if (bk_done.done) begin
      busy_nxt[bk_done.bank] = 1'b0;
    end
    if (accept) begin
      if (in_byte_present) begin
        cnt_a = cnt_r + CNT_W'(1);
        par_a = par_r ^ in_payload_byte;
        full  = (cnt_a == CNT_W'(PIECE_BYTES));
      end
      cnt_nxt = cnt_a;
      par_nxt = par_a;
      q_cmd.len   = 8'(cnt_a);
      q_cmd.ppar  = par_a;
      q_cmd.ftype = in_frame_type;
      q_cmd.bank  = bank_r;
      q_cmd.has_end = in_end_of_message;
      if (full) begin
        q_cmd.has_data   = 1'b1;
        q_push           = 1'b1;
        cnt_nxt          = '0;
        par_nxt          = '0;
        sent_nxt         = 1'b1;
        bank_nxt         = !bank_r;
        busy_nxt[bank_r] = 1'b1;
      end else if (in_end_of_message) begin
        q_cmd.has_data = (cnt_a != '0) || !sent_r;
        q_push         = 1'b1;
        if (cnt_a != '0) begin
          bank_nxt         = !bank_r;
          busy_nxt[bank_r] = 1'b1;
        end
      end
      if (in_end_of_message) begin
        cnt_nxt  = '0;
        par_nxt  = '0;
        sent_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      par_r  <= '0;
      sent_r <= 1'b0;
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      par_r  <= par_nxt;
      sent_r <= sent_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== rtl/core/sfb_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on sfb_pkg.
module sfb_queue import sfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/sfb_back.sv =====
// Back end: holds the two-bank piece store and sequences frame bytes onto
// the output register. Depends on sfb_pkg.
module sfb_back import sfb_pkg::*; #(
  parameter int PIECE_BYTES = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  mem_wr_t    mem_wr,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output back_done_t bk_done,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_frame_done,
  output logic       out_last
);

  localparam int DEPTH  = 2 * PIECE_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_LEN, S_SEQ, S_TYPE, S_PAY, S_PAR, S_PAD
  } state_t;

  logic [7:0] mem [DEPTH];

  state_t      state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        is_end_r, is_end_nxt;
  logic [7:0]  j_r, j_nxt, j_inc;
  logic [4:0]  pad_tot_r, pad_tot_nxt;
  logic [5:0]  res_r, res_nxt;
  logic [7:0]  rd_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_done_r, out_done_nxt;
  logic        out_last_r, out_last_nxt;

  logic        adv, emit, done, last;
  logic [7:0]  byte_val, f_len, f_type, f_ppar;
  logic [8:0]  tot;
  logic        padded;
  logic [7:0]  rd_idx;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  assign f_len  = is_end_r ? 8'd0 : cmd_r.len;
  assign f_type = is_end_r ? cfg.end_type : cmd_r.ftype;
  assign f_ppar = is_end_r ? 8'd0 : cmd_r.ppar;
  assign tot    = {1'b0, f_len} + 9'(FRAME_OVERHEAD);
  assign padded = tot < {4'd0, cfg.min_len};
  assign j_inc  = j_r + 8'd1;
  assign adv    = !out_valid_r || !out_stall;

  assign rd_idx  = (state_r == S_PAY && adv && j_inc != f_len) ? j_inc : j_r;
  assign rd_addr = cmd_r.bank ? ADDR_W'(PIECE_BYTES) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);
  assign wr_addr = mem_wr.bank ? ADDR_W'(PIECE_BYTES) + ADDR_W'(mem_wr.idx)
                               : ADDR_W'(mem_wr.idx);

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[wr_addr] <= mem_wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    is_end_nxt    = is_end_r;
    j_nxt         = j_r;
    pad_tot_nxt   = pad_tot_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_done_nxt  = out_done_r;
    out_last_nxt  = out_last_r;
    emit     = 1'b0;
    done     = 1'b0;
    byte_val = START_MARK;
    q_pop    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (adv && !q_empty) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_head;
          is_end_nxt = !q_head.has_data;
          res_nxt    = '0;
          state_nxt  = S_MARK;
        end
      end
      S_MARK: begin
        emit     = 1'b1;
        byte_val = START_MARK;
        if (adv) begin
          j_nxt     = '0;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        emit     = 1'b1;
        byte_val = f_len;
        if (adv) state_nxt = S_SEQ;
      end
      S_SEQ: begin
        emit     = 1'b1;
        byte_val = cfg.seq;
        if (adv) state_nxt = S_TYPE;
      end
      S_TYPE: begin
        emit     = 1'b1;
        byte_val = f_type;
        if (adv) state_nxt = (f_len != 8'd0) ? S_PAY : S_PAR;
      end
      S_PAY: begin
        emit     = 1'b1;
        byte_val = rd_data_r;
        if (adv) begin
          if (j_inc == f_len) begin
            state_nxt = S_PAR;
          end else begin
            j_nxt = j_inc;
          end
        end
      end
      S_PAR: begin
        emit     = 1'b1;
        byte_val = f_len ^ cfg.seq ^ f_type ^ f_ppar;
        done     = !padded;
        if (adv && padded) begin
          pad_tot_nxt = 5'(tot);
          state_nxt   = S_PAD;
        end
      end
      S_PAD: begin
        emit     = 1'b1;
        byte_val = cfg.pad;
        done     = ({1'b0, pad_tot_r} + 6'd1) == {1'b0, cfg.min_len};
        if (adv) pad_tot_nxt = pad_tot_r + 5'd1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    last = (done && (is_end_r || !cmd_r.has_end)) || (res_r == 6'(MAX_RESULTS - 1));

    if (adv) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_byte_nxt = byte_val;
        out_done_nxt = done;
        out_last_nxt = last;
        res_nxt      = res_r + 6'd1;
        if (last) begin
          state_nxt = S_IDLE;
        end else if (done) begin
          is_end_nxt = 1'b1;
          state_nxt  = S_MARK;
        end
      end
    end

    bk_done.done = adv && emit && last && cmd_r.has_data && (cmd_r.len != 8'd0);
    bk_done.bank = cmd_r.bank;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      is_end_r    <= 1'b0;
      j_r         <= '0;
      pad_tot_r   <= '0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      is_end_r    <= is_end_nxt;
      j_r         <= j_nxt;
      pad_tot_r   <= pad_tot_nxt;
      res_r       <= res_nxt;
    end
    cmd_r      <= cmd_nxt;
    out_byte_r <= out_byte_nxt;
    out_done_r <= out_done_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_frame_done = out_done_r;
  assign out_last       = out_last_r;

endmodule

// ===== rtl/core/segmenting_frame_builder_unit.sv =====
// Segmenting frame builder: cuts a byte stream into framed pieces.
// Input channel: one payload byte (or a bare end marker) per item, valid/stall.
// Output channel: one frame byte per item, valid/stall, from a register;
//   frame_done marks each frame's final byte, last the final byte caused by
//   one input item (at most 35 bytes per input item, the rest are dropped).
// Config channel: valid/ready write of sequence number, end type, minimum
//   frame length and pad byte; ready is always high. Write only when idle.
// Throughput: the front takes an input item whenever it does not stall; the
//   back end sends one frame byte per cycle while it holds a command and the
//   output does not stall; a full piece of 15 input items makes a frame of
//   20 or more bytes. The front stalls when the two-entry command queue is
//   full or, for an item with a byte, when the piece bank it fills is still
//   being sent.
// Reset (synchronous, rst_n low) empties the queue, drops any open piece and
//   loads the register defaults. A stall on the output holds the byte and
//   halts the sequencer; the front keeps accepting until the queue fills or a byte meets a busy bank.
// Depends on sfb_pkg, sfb_front, sfb_queue, sfb_back.
module segmenting_frame_builder_unit import sfb_pkg::*; #(
  parameter int PIECE_BYTES = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_message,
  input  logic [7:0] in_frame_type,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_frame_done,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t       cfg_r;
  logic       q_push, q_full, q_pop, q_empty;
  cmd_t       q_cmd, q_head;
  mem_wr_t    mem_wr;
  back_done_t bk_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seq      <= 8'd255;
      cfg_r.end_type <= 8'd13;
      cfg_r.min_len  <= 5'd16;
      cfg_r.pad      <= 8'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SEQ:      cfg_r.seq      <= cfg_data;
        CFG_END_TYPE: cfg_r.end_type <= cfg_data;
        CFG_MIN_LEN:  cfg_r.min_len  <= cfg_data[4:0];
        CFG_PAD:      cfg_r.pad      <= cfg_data;
        default: ;
      endcase
    end
  end

  sfb_front #(.PIECE_BYTES(PIECE_BYTES)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_payload_byte   (in_payload_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .in_frame_type     (in_frame_type),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (q_cmd),
    .mem_wr            (mem_wr),
    .bk_done           (bk_done)
  );

  sfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  sfb_back #(.PIECE_BYTES(PIECE_BYTES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .mem_wr         (mem_wr),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .bk_done        (bk_done),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_frame_done (out_frame_done),
    .out_last       (out_last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("command popped from an empty queue");

  a_release_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    bk_done.done |=> out_valid && out_last)
    else $error("piece bank released without a closing item");

endmodule

// ===== tb/sfb_frame_checker.sv =====
// Frame checker for the segmenting frame builder: tracks register writes, predicts
// the frame bytes of every accepted input item and compares them with the output.
// Depends on sfb_pkg.
module sfb_frame_checker import sfb_pkg::*; #(
  parameter int PIECE_BYTES = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_message,
  input  logic [7:0] in_frame_type,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_frame_done,
  input  logic       out_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         frames_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       done;
    logic       last;
  } frame_byte_t;

  cfg_t        regs;
  logic [7:0]  piece [PIECE_BYTES];
  int          piece_len;
  logic [7:0]  piece_par;
  logic        piece_sent;
  frame_byte_t item_bytes[$];
  frame_byte_t expected_bytes[$];

  function automatic void put_byte(logic [7:0] b, logic done);
    frame_byte_t fb;
    if (item_bytes.size() < MAX_RESULTS) begin
      fb.data = b;
      fb.done = done;
      fb.last = 1'b0;
      item_bytes.insert(item_bytes.size(), fb);
    end
  endfunction

  function automatic void put_frame(logic [7:0] ftype, int len, logic [7:0] ppar);
    int   total;
    logic padded;
    total  = len + FRAME_OVERHEAD;
    padded = total < int'(regs.min_len);
    put_byte(START_MARK, 1'b0);
    put_byte(8'(len), 1'b0);
    put_byte(regs.seq, 1'b0);
    put_byte(ftype, 1'b0);
    for (int j = 0; j < len; j++) put_byte(piece[j], 1'b0);
    put_byte(8'(len) ^ regs.seq ^ ftype ^ ppar, !padded);
    while (total < int'(regs.min_len)) begin
      total++;
      put_byte(regs.pad, total == int'(regs.min_len));
    end
  endfunction

  function automatic void predict_frames(logic [7:0] b, logic present, logic eom,
                                         logic [7:0] ftype);
    item_bytes.delete();
    if (present) begin
      if (piece_len < PIECE_BYTES) begin
        piece[piece_len] = b;
        piece_len++;
        piece_par ^= b;
      end
      if (piece_len >= PIECE_BYTES) begin
        put_frame(ftype, piece_len, piece_par);
        piece_sent = 1'b1;
        piece_len  = 0;
        piece_par  = 8'h00;
      end
    end
    if (eom) begin
      if (piece_len > 0 || !piece_sent) put_frame(ftype, piece_len, piece_par);
      put_frame(regs.end_type, 0, 8'h00);
      piece_len  = 0;
      piece_par  = 8'h00;
      piece_sent = 1'b0;
    end
    if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].last = 1'b1;
    foreach (item_bytes[k]) expected_bytes.insert(expected_bytes.size(), item_bytes[k]);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      regs        = '{seq: 8'd255, end_type: 8'd13, min_len: 5'd16, pad: 8'd32};
      piece_len   = 0;
      piece_par   = 8'h00;
      piece_sent  = 1'b0;
      fail_count  = 0;
      frames_seen = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SEQ:      regs.seq      = cfg_data;
          CFG_END_TYPE: regs.end_type = cfg_data;
          CFG_MIN_LEN:  regs.min_len  = cfg_data[4:0];
          CFG_PAD:      regs.pad      = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_frames(in_payload_byte, in_byte_present, in_end_of_message, in_frame_type);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: out_byte mismatch, expected none, got %0h", $time, out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_frame_done", 8'(want.done), 8'(out_frame_done));
          check_field("out_last", 8'(want.last), 8'(out_last));
          if (want.done) frames_seen++;
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// ===== tb/tb_segmenting_frame_builder_unit.sv =====
// Testbench top for segmenting_frame_builder_unit: drives messages in bursts,
// stalls the output, rewrites the registers between phases and gives the verdict.
// Depends on sfb_pkg, the block and sfb_frame_checker.
module tb_segmenting_frame_builder_unit;
  import sfb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIECE_BYTES   = 15;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 45;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_CHOKED} flow_t;

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic [7:0] in_payload_byte   = 8'h00;
  logic       in_byte_present   = 1'b0;
  logic       in_end_of_message = 1'b0;
  logic [7:0] in_frame_type     = 8'h00;
  logic       out_stall         = 1'b0;
  logic       cfg_valid         = 1'b0;
  logic [1:0] cfg_index         = CFG_SEQ;
  logic [7:0] cfg_data          = 8'h00;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_frame_done;
  logic       out_last;
  logic       cfg_ready;

  int    fail_count;
  int    pending;
  int    frames_seen;
  int    items_sent     = 0;
  int    message_items  = 0;
  int    settings_used  = 0;
  int    burst_left     = 0;
  int    idle_cycles    = 0;
  bit    valid_up       = 1'b0;
  flow_t flow_mode      = FLOW_FREE;
  int    flow_left      = 0;

  always #5 clk = ~clk;

  segmenting_frame_builder_unit #(.PIECE_BYTES(PIECE_BYTES)) i_dut (.*);

  sfb_frame_checker #(.PIECE_BYTES(PIECE_BYTES)) i_checker (.*);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (flow_left == 0) begin
      flow_mode <= flow_t'($urandom_range(0, 3));
      flow_left <= $urandom_range(10, 120);
    end else begin
      flow_left <= flow_left - 1;
    end
    case (flow_mode)
      FLOW_FREE:  out_stall <= 1'b0;
      FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic drive_item(input logic [7:0] b, input logic present, input logic eom,
                            input logic [7:0] ftype);
    in_valid          <= 1'b1;
    valid_up          = 1'b1;
    in_payload_byte   <= b;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    in_frame_type     <= ftype;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] seq, input logic [7:0] end_t,
                               input logic [7:0] min_raw, input logic [7:0] pad);
    cfg_idx_t   order [4];
    logic [7:0] vals [4];
    order = '{CFG_SEQ, CFG_END_TYPE, CFG_MIN_LEN, CFG_PAD};
    vals  = '{seq, end_t, min_raw, pad};
    cfg_valid <= 1'b1;
    for (int r = 0; r < 4; r++) begin
      cfg_index <= order[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic drive_message(input int len, input bit bare_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) drive_item(8'($urandom), 1'b0, 1'b0, 8'($urandom));
      drive_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end, 8'($urandom));
      message_items++;
    end
    if (bare_end || len == 0) begin
      drive_item(8'($urandom), 1'b0, 1'b1, 8'($urandom));
      message_items++;
    end
  endtask

  task automatic random_phase();
    int len;
    message_items = 0;
    while (message_items < PHASE_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = PIECE_BYTES * $urandom_range(1, 2);
        2:       len = PIECE_BYTES - 1 + $urandom_range(0, 2);
        default: len = $urandom_range(1, 20);
      endcase
      drive_message(len, 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    drive_item(8'h00, 1'b0, 1'b1, 8'h00);
    drive_item(8'hA5, 1'b0, 1'b0, 8'h5A);
    drive_item(8'h00, 1'b1, 1'b1, 8'hFF);
    for (int i = 0; i < PIECE_BYTES; i++)
      drive_item(i[0] ? 8'h00 : 8'hFF, 1'b1, i == PIECE_BYTES - 1, 8'h80);
    drive_item(8'h55, 1'b1, 1'b0, 8'h01);
    drive_item(8'hFF, 1'b0, 1'b1, 8'hAA);
    drain();
    load_settings(8'h00, 8'h00, 8'h00, 8'h00);
    random_phase();
    load_settings(8'hFF, 8'hFF, 8'h1F, 8'hFF);
    random_phase();
    load_settings(8'hA5, 8'h5A, 8'hE5, 8'h0F);
    random_phase();
    repeat (3) begin
      load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      random_phase();
    end
    $display("Sent %0d input items over %0d register settings; %0d frames checked,",
             items_sent, settings_used + 1, frames_seen);
    $display("covering empty, exact-multiple, padded and truncated messages.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
